>>> sv/kth_pkg.sv
// Shared types, codes and constants for the k-th smallest element search block.
`timescale 1ns / 1ps
`default_nettype none
package kth_pkg;

	localparam int DEPTH_DEF = 256;
	localparam int VAL_W     = 32;
	localparam int RANK_W    = 10;
	localparam int OP_W      = 2;

	localparam logic signed [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum logic [OP_W-1:0] {
		OP_APPEND_A = 2'd0,
		OP_APPEND_B = 2'd1,
		OP_QUERY    = 2'd2,
		OP_CLEAR    = 2'd3
	} kth_op_t;

	typedef enum logic {
		ST_FOUND = 1'b0,
		ST_RANGE = 1'b1
	} kth_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ITER,
		S_RDL,
		S_RDR,
		S_DONE
	} kth_state_t;

	typedef struct packed {
		kth_status_t             status;
		logic signed [VAL_W-1:0] element;
	} kth_result_t;

	typedef struct packed {
		logic        idle;
		logic        done;
		kth_result_t result;
	} kth_search_stat_t;

endpackage
`default_nettype wire

>>> sv/kth_in_if.sv
// Request channel: operation, value and rank with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface kth_in_if;
	import kth_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic signed [VAL_W-1:0] value;
	logic [RANK_W-1:0]       rank;

	modport source (output valid, output operation, output value, output rank, input ready);
	modport sink (input valid, input operation, input value, input rank, output ready);
endinterface
`default_nettype wire

>>> sv/kth_out_if.sv
// Response channel: status and element with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface kth_out_if;
	import kth_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    status;
	logic signed [VAL_W-1:0] element;

	modport source (output valid, output status, output element, input ready);
	modport sink (input valid, input status, input element, output ready);
endinterface
`default_nettype wire

>>> sv/kth_ram.sv
// Element store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kth_ram #(
	parameter int DEPTH = kth_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [AW-1:0]                   waddr,
	input  wire logic signed [kth_pkg::VAL_W-1:0] wdata,
	input  wire logic [AW-1:0]                   raddr,
	output logic signed [kth_pkg::VAL_W-1:0]      rdata_q
);
	import kth_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> sv/kth_search.sv
// Binary search over the cut point of the shorter array, two reads per memory per step.
`timescale 1ns / 1ps
`default_nettype none
module kth_search #(
	parameter int DEPTH = kth_pkg::DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [kth_pkg::RANK_W-1:0]       rank,
	input  wire logic [CW-1:0]                    first_count,
	input  wire logic [CW-1:0]                    second_count,
	input  wire logic                             out_free,
	output logic [AW-1:0]                         addr_a,
	output logic [AW-1:0]                         addr_b,
	input  wire logic signed [kth_pkg::VAL_W-1:0]  rd_a,
	input  wire logic signed [kth_pkg::VAL_W-1:0]  rd_b,
	output kth_pkg::kth_search_stat_t             stat
);
	import kth_pkg::*;

	localparam int SW = (((CW + 1) > RANK_W) ? (CW + 1) : RANK_W) + 1;

	kth_state_t state_q, state_d;

	logic                    sw_q;
	logic signed [SW-1:0]    k_q, ns_q, nl_q, low_q, high_q, c1_q, c2_q;
	logic signed [VAL_W-1:0] l1_q, l2_q;
	kth_result_t             res_q;

	logic signed [SW-1:0] k_in, m_in, n_in, sum_in, ns_in, nl_in, lo_in, hi_in;
	logic signed [SW-1:0] mid_c1, mid_c2, sa_pre, la_pre;
	logic                 bad_in, swap_in, bounds_ok, part_ok, go_left;
	logic signed [VAL_W-1:0] s_rd, l_rd, r1, r2;
	logic [AW-1:0]        s_addr, l_addr;

	assign k_in    = $signed({{(SW-RANK_W){1'b0}}, rank});
	assign m_in    = $signed({{(SW-CW){1'b0}}, first_count});
	assign n_in    = $signed({{(SW-CW){1'b0}}, second_count});
	assign sum_in  = m_in + n_in;
	assign bad_in  = (k_in == '0) || (k_in > sum_in);
	assign swap_in = m_in > n_in;
	assign ns_in   = swap_in ? n_in : m_in;
	assign nl_in   = swap_in ? m_in : n_in;
	assign lo_in   = (k_in > nl_in) ? (k_in - nl_in) : '0;
	assign hi_in   = (k_in < ns_in) ? k_in : ns_in;

	assign bounds_ok = low_q <= high_q;
	assign mid_c1    = low_q + ((high_q - low_q) >>> 1);
	assign mid_c2    = k_q - mid_c1;

	assign s_rd    = sw_q ? rd_b : rd_a;
	assign l_rd    = sw_q ? rd_a : rd_b;
	assign r1      = (c1_q == ns_q) ? INT_MAX : s_rd;
	assign r2      = (c2_q == nl_q) ? INT_MAX : l_rd;
	assign part_ok = (l1_q <= r2) && (l2_q <= r1);
	assign go_left = l1_q > r2;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = bad_in ? S_DONE : S_ITER;
			end
			S_ITER: state_d = bounds_ok ? S_RDL : S_DONE;
			S_RDL:  state_d = S_RDR;
			S_RDR:  state_d = part_ok ? S_DONE : S_ITER;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		sa_pre      = c1_q;
		la_pre      = c2_q;
		stat.idle   = 1'b0;
		stat.done   = 1'b0;
		stat.result = res_q;
		unique case (state_q)
			S_IDLE: stat.idle = 1'b1;
			S_ITER: begin
				sa_pre = mid_c1 - 1'b1;
				la_pre = mid_c2 - 1'b1;
			end
			S_DONE: stat.done = out_free;
			default: ;
		endcase
		s_addr = sa_pre[AW-1:0];
		l_addr = la_pre[AW-1:0];
		addr_a = sw_q ? l_addr : s_addr;
		addr_b = sw_q ? s_addr : l_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			low_q   <= '0;
			high_q  <= '0;
			sw_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				low_q  <= lo_in;
				high_q <= hi_in;
				sw_q   <= swap_in;
			end else if (state_q == S_RDR && !part_ok) begin
				if (go_left) high_q <= c1_q - 1'b1;
				else         low_q  <= c1_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				k_q   <= k_in;
				ns_q  <= ns_in;
				nl_q  <= nl_in;
				res_q <= '{status: ST_RANGE, element: '0};
			end
			S_ITER: begin
				c1_q <= mid_c1;
				c2_q <= mid_c2;
			end
			S_RDL: begin
				l1_q <= (c1_q == '0) ? INT_MIN : s_rd;
				l2_q <= (c2_q == '0) ? INT_MIN : l_rd;
			end
			S_RDR: begin
				if (part_ok) res_q <= '{status: ST_FOUND, element: (l1_q > l2_q) ? l1_q : l2_q};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> sv/kth_of_two_sorted_arrays.sv
// Top level: element stores, fill counts, search unit and response register.
//  channel | dir | fields                      | transfer when
//  req     | in  | operation, value, rank      | req.valid && req.ready
//  rsp     | out | status, element             | rsp.valid && rsp.ready
// A query runs I search steps, I at most floor(log2(min(m,n)+1)) + 1; each step reads
// both element memories twice through their single read ports.
// Reset clears counts and control; stored elements are not cleared.
// req.ready is low while a query runs; a finished query waits until rsp is free.
`timescale 1ns / 1ps
`default_nettype none
module kth_of_two_sorted_arrays #(
	parameter int DEPTH = kth_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	kth_in_if.sink   req,
	kth_out_if.source rsp
);
	import kth_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0]      first_count_q, second_count_q;
	logic               out_valid_q;
	kth_result_t        out_q;
	kth_search_stat_t   stat;
	logic               take, we_a, we_b, start, out_free;
	kth_op_t            op;
	logic [AW-1:0]      addr_a, addr_b;
	logic signed [VAL_W-1:0] rd_a, rd_b;

	assign req.ready = stat.idle;
	assign take      = req.valid && req.ready;
	assign op        = kth_op_t'(req.operation);
	assign we_a      = take && (op == OP_APPEND_A) && (first_count_q < DEPTH_C);
	assign we_b      = take && (op == OP_APPEND_B) && (second_count_q < DEPTH_C);
	assign start     = take && (op == OP_QUERY);
	assign out_free  = !out_valid_q || rsp.ready;

	kth_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_a (
		.clk    (clk),
		.we     (we_a),
		.waddr  (first_count_q[AW-1:0]),
		.wdata  (req.value),
		.raddr  (addr_a),
		.rdata_q(rd_a)
	);

	kth_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram_b (
		.clk    (clk),
		.we     (we_b),
		.waddr  (second_count_q[AW-1:0]),
		.wdata  (req.value),
		.raddr  (addr_b),
		.rdata_q(rd_b)
	);

	kth_search #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.rank        (req.rank),
		.first_count (first_count_q),
		.second_count(second_count_q),
		.out_free    (out_free),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.rd_a        (rd_a),
		.rd_b        (rd_b),
		.stat        (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_count_q  <= '0;
			second_count_q <= '0;
		end else if (take) begin
			unique case (op)
				OP_APPEND_A: if (we_a) first_count_q <= first_count_q + 1'b1;
				OP_APPEND_B: if (we_b) second_count_q <= second_count_q + 1'b1;
				OP_CLEAR: begin
					first_count_q  <= '0;
					second_count_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) out_q <= stat.result;
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_q.status;
	assign rsp.element = out_q.element;
endmodule
`default_nettype wire
